// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge, off while reset is asserted.
`define KRLT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Expression that must never be true.
`define KRLT_NEVER(lbl, clk, rst_n, expr) \
  `KRLT_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define KRLT_ASSERT(lbl, clk, rst_n, prop)
`define KRLT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/krlt_pkg.sv -----
// ----------------------------------------------------------------------------
// krlt_pkg
// Types, codes and constants of the keyed record list table.
// ----------------------------------------------------------------------------
package krlt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int NAME_BYTES  = 20;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] score;
    logic [63:0] name_high;
    logic [63:0] name_middle;
    logic [31:0] name_low;
  } rec_t;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_DELETE  = 3'd1,
    ACT_SEARCH  = 3'd2,
    ACT_SORT    = 3'd3,
    ACT_DISPLAY = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_ROTATE   = 3'd2,
    OP_COMPRESS = 3'd3,
    OP_SORT     = 3'd4
  } cell_op_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] count;
    logic             phase;
    rec_t             wdata;
  } cell_ctrl_t;

  // Keeps name bytes first..first+nbytes-1; lowest byte sits in the top bits.
  function automatic logic [63:0] name_mask(input int first, input int nbytes);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < nbytes && first + i < NAME_BYTES) begin
        m = m | (64'hFF << ((nbytes - 1 - i) * 8));
      end
    end
    return m;
  endfunction

  localparam logic [63:0] NAME_MASK_HIGH   = name_mask(0, 8);
  localparam logic [63:0] NAME_MASK_MIDDLE = name_mask(8, 8);
  localparam logic [31:0] NAME_MASK_LOW    = 32'(name_mask(16, 4));

endpackage

// ----- rtl/keyed_record_list_table_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_record_list_table_unit
// Ordered record table built as a chain of record cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. action_i picks insert, delete, search, sort or display; codes
//   above display are dropped with no result.
//   Result channel: result_valid_o strobes one cycle per result; last_o
//   marks the final result of a command. The receiver cannot stall.
// Command flow:
//   Insert, and any command on an empty table, gives its result in the
//   cycle after the transfer and busy stays low: one command per cycle.
//   Delete, search, sort and display hold busy for a pass over the
//   entries. Each step the live ring of cells rotates by one (or, for
//   sort, does one odd/even compare-exchange round), so the chain is
//   back in table order when the pass ends. Search and delete report in
//   the cycle after the hit reaches cell 0; display emits one record per
//   cycle; sort and a miss report in the cycle after the final step.
// Reset: entry count clears to zero; record cells are not cleared, only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_record_list_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [15:0] key_i,
  input  logic [15:0] score_i,
  input  logic [63:0] name_high_i,
  input  logic [63:0] name_middle_i,
  input  logic [31:0] name_low_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] out_key_o,
  output logic [15:0] out_score_o,
  output logic [63:0] out_name_high_o,
  output logic [63:0] out_name_middle_o,
  output logic [31:0] out_name_low_o,
  output logic        last_o
);

  localparam int N = krlt_pkg::MAX_ENTRIES;
  localparam int CW = krlt_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e               state_q, state_d;
  krlt_pkg::action_e    act_q, act_d;
  logic [15:0]          key_q, key_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rem_q, rem_d;     // steps left in the pass
  logic                 found_q, found_d;
  logic                 phase_q, phase_d;

  logic                 valid_q, valid_d;
  krlt_pkg::status_e    status_q, status_d;
  krlt_pkg::rec_t       res_q, res_d;
  logic                 last_q, last_d;

  krlt_pkg::cell_ctrl_t ctrl;
  krlt_pkg::rec_t       cell_rec   [N];
  krlt_pkg::rec_t       left_rec   [N];
  krlt_pkg::rec_t       right_rec  [N];
  krlt_pkg::rec_t       head;
  krlt_pkg::rec_t       new_rec;

  logic                 accept;
  logic                 hit;
  logic                 final_step;
  logic                 lookup;

  assign accept = start && !busy;
  assign head   = cell_rec[0];

  // insert payload, name bytes past the configured length forced to zero
  assign new_rec.key         = key_i;
  assign new_rec.score       = score_i;
  assign new_rec.name_high   = name_high_i & krlt_pkg::NAME_MASK_HIGH;
  assign new_rec.name_middle = name_middle_i & krlt_pkg::NAME_MASK_MIDDLE;
  assign new_rec.name_low    = name_low_i & krlt_pkg::NAME_MASK_LOW;

  assign lookup     = (act_q == krlt_pkg::ACT_DELETE) || (act_q == krlt_pkg::ACT_SEARCH);
  assign hit        = lookup && !found_q && (head.key == key_q);
  assign final_step = (rem_q == CW'(1));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    key_d    = key_q;
    count_d  = count_q;
    rem_d    = rem_q;
    found_d  = found_q;
    phase_d  = phase_q;
    valid_d  = 1'b0;
    status_d = status_q;
    res_d    = res_q;
    last_d   = last_q;

    ctrl.op    = krlt_pkg::OP_HOLD;
    ctrl.count = count_q;
    ctrl.phase = phase_q;
    ctrl.wdata = new_rec;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d  = '0;
          last_d = 1'b1;
          priority case (action_i)
            krlt_pkg::ACT_INSERT: begin
              valid_d = 1'b1;
              if (count_q == CW'(N)) begin
                status_d = krlt_pkg::ST_FULL;
              end else begin
                status_d = krlt_pkg::ST_OK;
                ctrl.op  = krlt_pkg::OP_WRITE;
                count_d  = count_q + CW'(1);
              end
            end
            krlt_pkg::ACT_DELETE, krlt_pkg::ACT_SEARCH,
            krlt_pkg::ACT_SORT, krlt_pkg::ACT_DISPLAY: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = krlt_pkg::ST_EMPTY;
              end else begin
                state_d = S_RUN;
                act_d   = krlt_pkg::action_e'(action_i);
                key_d   = key_i;
                rem_d   = count_q;
                found_d = 1'b0;
                phase_d = 1'b0;
              end
            end
            default: begin
              // unknown code: dropped
            end
          endcase
        end
      end
      S_RUN: begin
        rem_d = rem_q - CW'(1);
        if (final_step) state_d = S_IDLE;

        if (act_q == krlt_pkg::ACT_SORT) begin
          ctrl.op = krlt_pkg::OP_SORT;
          phase_d = !phase_q;
        end else if (hit && act_q == krlt_pkg::ACT_DELETE) begin
          ctrl.op = krlt_pkg::OP_COMPRESS;
          count_d = count_q - CW'(1);
        end else begin
          ctrl.op = krlt_pkg::OP_ROTATE;
        end

        priority if (act_q == krlt_pkg::ACT_DISPLAY) begin
          valid_d  = 1'b1;
          status_d = krlt_pkg::ST_OK;
          res_d    = head;
          last_d   = final_step;
        end else if (hit) begin
          valid_d  = 1'b1;
          status_d = krlt_pkg::ST_OK;
          res_d    = head;
          last_d   = 1'b1;
          found_d  = 1'b1;
        end else if (final_step && lookup && !found_q) begin
          valid_d  = 1'b1;
          status_d = krlt_pkg::ST_NOT_FOUND;
          res_d    = '0;
          last_d   = 1'b1;
        end else if (final_step && act_q == krlt_pkg::ACT_SORT) begin
          valid_d  = 1'b1;
          status_d = krlt_pkg::ST_OK;
          res_d    = '0;
          last_d   = 1'b1;
        end else begin
          valid_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rem_q   <= '0;
      found_q <= 1'b0;
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      found_q <= found_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    status_q <= status_d;
    res_q    <= res_d;
    last_q   <= last_d;
  end

  // --------------------------------------------------------------------------
  // Cell chain: cell j holds entry j between commands
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < N; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign left_rec[j] = '0;
    end else begin : g_inner_l
      assign left_rec[j] = cell_rec[j-1];
    end
    if (j == N - 1) begin : g_last
      assign right_rec[j] = '0;
    end else begin : g_inner_r
      assign right_rec[j] = cell_rec[j+1];
    end

    krlt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (krlt_pkg::IDX_W'(j)),
      .left_i  (left_rec[j]),
      .right_i (right_rec[j]),
      .head_i  (head),
      .rec_o   (cell_rec[j])
    );
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign busy              = (state_q == S_RUN);
  assign result_valid_o    = valid_q;
  assign status_o          = status_q;
  assign out_key_o         = res_q.key;
  assign out_score_o       = res_q.score;
  assign out_name_high_o   = res_q.name_high;
  assign out_name_middle_o = res_q.name_middle;
  assign out_name_low_o    = res_q.name_low;
  assign last_o            = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `KRLT_NEVER(a_count_range, clk_i, rst_ni, count_q > CW'(N))
  `KRLT_ASSERT(a_run_no_grow, clk_i, rst_ni, busy |=> (count_q <= $past(count_q)))
  `KRLT_ASSERT(a_unknown_silent, clk_i, rst_ni, (accept && action_i > krlt_pkg::ACT_DISPLAY) |=> !valid_q)
  `KRLT_ASSERT(a_insert_reply, clk_i, rst_ni, (accept && action_i == krlt_pkg::ACT_INSERT) |=> (valid_q && last_q))

endmodule

// ----- rtl/krlt_cell.sv -----
// ----------------------------------------------------------------------------
// krlt_cell
// One table slot: holds a record, trades it with its neighbors.
// ----------------------------------------------------------------------------
module krlt_cell (
  input  logic                     clk_i,
  input  krlt_pkg::cell_ctrl_t     ctrl_i,
  input  logic [krlt_pkg::IDX_W-1:0] idx_i,
  input  krlt_pkg::rec_t           left_i,
  input  krlt_pkg::rec_t           right_i,
  input  krlt_pkg::rec_t           head_i,
  output krlt_pkg::rec_t           rec_o
);

  krlt_pkg::rec_t rec_q, rec_d;
  logic [krlt_pkg::CNT_W-1:0] idx_ext;
  logic [krlt_pkg::CNT_W-1:0] idx_nxt;

  assign idx_ext = krlt_pkg::CNT_W'(idx_i);
  assign idx_nxt = idx_ext + krlt_pkg::CNT_W'(1);

  always_comb begin
    rec_d = rec_q;
    unique case (ctrl_i.op)
      krlt_pkg::OP_HOLD: begin
        rec_d = rec_q;
      end
      krlt_pkg::OP_WRITE: begin
        if (idx_ext == ctrl_i.count) rec_d = ctrl_i.wdata;
      end
      krlt_pkg::OP_ROTATE: begin
        // tail of the live ring wraps to the head
        if (idx_nxt == ctrl_i.count) rec_d = head_i;
        else if (idx_nxt < ctrl_i.count) rec_d = right_i;
      end
      krlt_pkg::OP_COMPRESS: begin
        if (idx_nxt < ctrl_i.count) rec_d = right_i;
      end
      krlt_pkg::OP_SORT: begin
        if (idx_i[0] == ctrl_i.phase) begin
          // lower cell of a pair
          if (idx_nxt < ctrl_i.count && rec_q.key > right_i.key) rec_d = right_i;
        end else begin
          if (idx_ext < ctrl_i.count && idx_i != '0 && left_i.key > rec_q.key) begin
            rec_d = left_i;
          end
        end
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ----- tb/keyed_record_list_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_record_list_table_checker
// Watches the command and result ports, predicts the table's replies and
// compares every result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module keyed_record_list_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  action_i,
  input  logic [15:0] key_i,
  input  logic [15:0] score_i,
  input  logic [63:0] name_high_i,
  input  logic [63:0] name_middle_i,
  input  logic [31:0] name_low_i,
  input  logic        result_valid_o,
  input  logic [1:0]  status_o,
  input  logic [15:0] out_key_o,
  input  logic [15:0] out_score_o,
  input  logic [63:0] out_name_high_o,
  input  logic [63:0] out_name_middle_o,
  input  logic [31:0] out_name_low_o,
  input  logic        last_o,
  output int          fail_count,
  output int          pending_count,
  output int          fill_level,
  output int          peak_fill,
  output int          commands_seen,
  output int          results_seen,
  output int          full_rejects
);

  typedef struct packed {
    krlt_pkg::status_e status;
    krlt_pkg::rec_t    rec;
    logic              last;
  } reply_t;

  krlt_pkg::rec_t record_table [krlt_pkg::MAX_ENTRIES];
  reply_t         reply_q [$];

  function automatic reply_t make_reply(input krlt_pkg::status_e st,
                                        input krlt_pkg::rec_t r, input logic lst);
    reply_t rp;
    rp.status = st;
    rp.rec    = r;
    rp.last   = lst;
    return rp;
  endfunction

  // Table update and expected replies for one accepted command.
  task automatic apply_command(input logic [2:0] act, input krlt_pkg::rec_t cmd);
    int             hit;
    krlt_pkg::rec_t held;
    hit = -1;
    if (act > krlt_pkg::ACT_DISPLAY) begin
      // unused codes: dropped silently
    end else if (act == krlt_pkg::ACT_INSERT) begin
      if (fill_level >= krlt_pkg::MAX_ENTRIES) begin
        reply_q.push_back(make_reply(krlt_pkg::ST_FULL, '0, 1'b1));
        full_rejects++;
      end else begin
        record_table[fill_level] = cmd;
        fill_level++;
        if (fill_level > peak_fill) peak_fill = fill_level;
        reply_q.push_back(make_reply(krlt_pkg::ST_OK, '0, 1'b1));
      end
    end else if (fill_level == 0) begin
      reply_q.push_back(make_reply(krlt_pkg::ST_EMPTY, '0, 1'b1));
    end else if (act == krlt_pkg::ACT_DELETE || act == krlt_pkg::ACT_SEARCH) begin
      for (int i = 0; i < fill_level; i++) begin
        if (hit < 0 && record_table[i].key == cmd.key) hit = i;
      end
      if (hit < 0) begin
        reply_q.push_back(make_reply(krlt_pkg::ST_NOT_FOUND, '0, 1'b1));
      end else begin
        reply_q.push_back(make_reply(krlt_pkg::ST_OK, record_table[hit], 1'b1));
        if (act == krlt_pkg::ACT_DELETE) begin
          for (int i = hit; i + 1 < fill_level; i++) record_table[i] = record_table[i + 1];
          fill_level--;
        end
      end
    end else if (act == krlt_pkg::ACT_SORT) begin
      // stable: swap only on strictly greater keys
      for (int p = 0; p + 1 < fill_level; p++) begin
        for (int j = 0; j + 1 < fill_level; j++) begin
          if (record_table[j].key > record_table[j + 1].key) begin
            held                = record_table[j];
            record_table[j]     = record_table[j + 1];
            record_table[j + 1] = held;
          end
        end
      end
      reply_q.push_back(make_reply(krlt_pkg::ST_OK, '0, 1'b1));
    end else begin
      for (int i = 0; i < fill_level; i++) begin
        reply_q.push_back(make_reply(krlt_pkg::ST_OK, record_table[i],
                                     i == fill_level - 1));
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    krlt_pkg::rec_t cmd;
    reply_t         want;
    if (!rst_ni) begin
      reply_q.delete();
      fail_count    = 0;
      pending_count = 0;
      fill_level    = 0;
      peak_fill     = 0;
      commands_seen = 0;
      results_seen  = 0;
      full_rejects  = 0;
    end else begin
      // a result never belongs to a command accepted at the same edge
      if (result_valid_o) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d key %h last %b",
                   $time, status_o, out_key_o, last_o);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("status",      64'(want.status),          64'(status_o));
          check_field("key",         64'(want.rec.key),         64'(out_key_o));
          check_field("score",       64'(want.rec.score),       64'(out_score_o));
          check_field("name_high",   want.rec.name_high,        out_name_high_o);
          check_field("name_middle", want.rec.name_middle,      out_name_middle_o);
          check_field("name_low",    64'(want.rec.name_low),    64'(out_name_low_o));
          check_field("last",        64'(want.last),            64'(last_o));
        end
      end
      if (start && !busy) begin
        commands_seen++;
        cmd.key         = key_i;
        cmd.score       = score_i;
        cmd.name_high   = name_high_i & krlt_pkg::NAME_MASK_HIGH;
        cmd.name_middle = name_middle_i & krlt_pkg::NAME_MASK_MIDDLE;
        cmd.name_low    = name_low_i & krlt_pkg::NAME_MASK_LOW;
        apply_command(action_i, cmd);
      end
      pending_count = reply_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the keyed record list table: a directed opening on
// the corner cases, then phases that fill, churn and drain the table.
// ----------------------------------------------------------------------------
module testbench;

  // Enough for a full display drained after the last command.
  localparam int TAIL_CYCLES      = 2 * krlt_pkg::MAX_ENTRIES + 16;
  localparam int DRAIN_LIMIT      = 4000;
  localparam int RANDOM_COMMANDS  = 410;
  localparam int KEY_POOL_SIZE    = 12;
  localparam int LAST_ACTION_CODE = 7;

  typedef enum {PH_FILL, PH_CHURN, PH_DRAIN} phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action_i = krlt_pkg::ACT_INSERT;
  logic [15:0] key_i = '0;
  logic [15:0] score_i = '0;
  logic [63:0] name_high_i = '0;
  logic [63:0] name_middle_i = '0;
  logic [31:0] name_low_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [15:0] out_key_o;
  logic [15:0] out_score_o;
  logic [63:0] out_name_high_o;
  logic [63:0] out_name_middle_o;
  logic [31:0] out_name_low_o;
  logic        last_o;

  int fail_count, pending_count, fill_level, peak_fill;
  int commands_seen, results_seen, full_rejects;

  // No idle gaps while set: back-to-back transfers.
  bit          no_idle = 1'b0;
  logic [15:0] key_pool [KEY_POOL_SIZE];
  logic [15:0] recent_keys [$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  keyed_record_list_table_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .key_i             (key_i),
    .score_i           (score_i),
    .name_high_i       (name_high_i),
    .name_middle_i     (name_middle_i),
    .name_low_i        (name_low_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .out_key_o         (out_key_o),
    .out_score_o       (out_score_o),
    .out_name_high_o   (out_name_high_o),
    .out_name_middle_o (out_name_middle_o),
    .out_name_low_o    (out_name_low_o),
    .last_o            (last_o)
  );

  keyed_record_list_table_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .key_i             (key_i),
    .score_i           (score_i),
    .name_high_i       (name_high_i),
    .name_middle_i     (name_middle_i),
    .name_low_i        (name_low_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .out_key_o         (out_key_o),
    .out_score_o       (out_score_o),
    .out_name_high_o   (out_name_high_o),
    .out_name_middle_o (out_name_middle_o),
    .out_name_low_o    (out_name_low_o),
    .last_o            (last_o),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .fill_level        (fill_level),
    .peak_fill         (peak_fill),
    .commands_seen     (commands_seen),
    .results_seen      (results_seen),
    .full_rejects      (full_rejects)
  );

  // Mostly short gaps, now and then a long one so that idle cycles land
  // in the middle of running sorts and displays.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Called at a falling edge. Holds start until a rising edge sees busy
  // low (the transfer), then idles for a random gap. With no gap start is
  // left high so the next command follows without a bubble.
  task automatic send_cmd(input logic [2:0] act, input logic [15:0] k,
                          input logic [15:0] s, input logic [63:0] nh,
                          input logic [63:0] nm, input logic [31:0] nl);
    int gap;
    start         <= 1'b1;
    action_i      <= act;
    key_i         <= k;
    score_i       <= s;
    name_high_i   <= nh;
    name_middle_i <= nm;
    name_low_i    <= nl;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (act == krlt_pkg::ACT_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > krlt_pkg::MAX_ENTRIES) void'(recent_keys.pop_front());
    end
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Insert keys come mostly from a small pool so duplicates (for the
  // stable sort and first-match rules) are common.
  function automatic logic [15:0] insert_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  // Lookup keys favor ones already inserted so deletes and searches hit.
  function automatic logic [15:0] lookup_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 90) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  function automatic logic [2:0] pick_action(input phase_e ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 80) return krlt_pkg::ACT_INSERT;
        if (r < 85) return krlt_pkg::ACT_SEARCH;
        if (r < 88) return krlt_pkg::ACT_DELETE;
        if (r < 92) return krlt_pkg::ACT_SORT;
        if (r < 97) return krlt_pkg::ACT_DISPLAY;
      end
      PH_CHURN: begin
        if (r < 30) return krlt_pkg::ACT_INSERT;
        if (r < 52) return krlt_pkg::ACT_DELETE;
        if (r < 72) return krlt_pkg::ACT_SEARCH;
        if (r < 84) return krlt_pkg::ACT_SORT;
        if (r < 96) return krlt_pkg::ACT_DISPLAY;
      end
      default: begin
        if (r < 70) return krlt_pkg::ACT_DELETE;
        if (r < 80) return krlt_pkg::ACT_SEARCH;
        if (r < 85) return krlt_pkg::ACT_INSERT;
        if (r < 90) return krlt_pkg::ACT_SORT;
        if (r < 96) return krlt_pkg::ACT_DISPLAY;
      end
    endcase
    return 3'($urandom_range(int'(krlt_pkg::ACT_DISPLAY) + 1, LAST_ACTION_CODE));
  endfunction

  initial begin
    phase_e      ph;
    logic [2:0]  act;
    logic [15:0] k;
    int          counted, at_full, phase_left, guard;

    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed opening --------------------------------------------------
    // every lookup-style command on an empty table
    send_cmd(krlt_pkg::ACT_SEARCH,  16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DELETE,  16'hFFFF, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_SORT,    16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DISPLAY, 16'h0000, '0, '0, '0, '0);
    // unused codes leave no trace
    for (int code = int'(krlt_pkg::ACT_DISPLAY) + 1; code <= LAST_ACTION_CODE; code++)
      send_cmd(3'(code), 16'hFFFF, 16'hFFFF, '1, '1, '1);
    // field extremes, plus a duplicate key to test first match and stability
    send_cmd(krlt_pkg::ACT_INSERT, 16'hFFFF, 16'h0000, '1, '1, '1);
    send_cmd(krlt_pkg::ACT_INSERT, 16'h0000, 16'hFFFF, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_INSERT, 16'h1234, 16'h5A5A, {$urandom, $urandom},
             {$urandom, $urandom}, $urandom);
    send_cmd(krlt_pkg::ACT_INSERT, 16'h0000, 16'h0001, {$urandom, $urandom},
             {$urandom, $urandom}, $urandom);
    send_cmd(krlt_pkg::ACT_INSERT, 16'h8000, 16'h8000, 64'h8000_0000_0000_0001,
             64'h0123_4567_89AB_CDEF, 32'h8000_0001);
    send_cmd(krlt_pkg::ACT_SEARCH,  16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_SEARCH,  16'h4321, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DELETE,  16'h4321, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DISPLAY, 16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_SORT,    16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DISPLAY, 16'h0000, '0, '0, '0, '0);
    // after the sort: remove the head, then the tail, then a middle record
    send_cmd(krlt_pkg::ACT_DELETE,  16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DELETE,  16'hFFFF, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DELETE,  16'h1234, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DISPLAY, 16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DELETE,  16'h0000, '0, '0, '0, '0);
    send_cmd(krlt_pkg::ACT_DELETE,  16'h8000, '0, '0, '0, '0);
    // emptied by deletes rather than by reset
    send_cmd(krlt_pkg::ACT_SEARCH,  16'h8000, '0, '0, '0, '0);
    recent_keys.delete();

    // ---- random phases -----------------------------------------------------
    // Fill to capacity and push a few inserts past it, churn with a mix of
    // everything, then drain with deletes; repeat until the budget is spent.
    ph = PH_FILL;
    at_full = 0;
    phase_left = 0;
    counted = 0;
    while (counted < RANDOM_COMMANDS) begin
      act = pick_action(ph);
      k = (act == krlt_pkg::ACT_INSERT) ? insert_key() : lookup_key();
      send_cmd(act, k, 16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
               $urandom);
      if (act <= krlt_pkg::ACT_DISPLAY) counted++;
      case (ph)
        PH_FILL: begin
          if (fill_level == krlt_pkg::MAX_ENTRIES) at_full++;
          if (at_full >= 4) begin
            ph = PH_CHURN;
            phase_left = $urandom_range(30, 60);
            no_idle = ($urandom_range(0, 2) == 0);
          end
        end
        PH_CHURN: begin
          phase_left--;
          if (phase_left <= 0) begin
            ph = PH_DRAIN;
            phase_left = 2 * krlt_pkg::MAX_ENTRIES + 40;
            no_idle = 1'b0;
          end
        end
        default: begin
          phase_left--;
          if (fill_level == 0 || phase_left <= 0) begin
            ph = PH_FILL;
            at_full = 0;
          end
        end
      endcase
    end
    start <= 1'b0;

    // ---- wind down ---------------------------------------------------------
    guard = 0;
    while (pending_count != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (pending_count != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_count);

    $display("Covered %0d commands and %0d compared results; table peaked at %0d records.",
             commands_seen, results_seen, peak_fill);
    $display("Inserts turned away by a full table: %0d.", full_rejects);
    if (fail_count == 0 && pending_count == 0) begin
      $display("keyed_record_list_table_unit test passed");
    end else begin
      $display("keyed_record_list_table_unit test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("keyed_record_list_table_unit test failed");
    $finish;
  end

endmodule
